/* sv/swm_pkg.sv */
// Shared constants and types for the sliding-window median filter.
// No dependencies; imported by swm_cell, swm_sort_chain and sliding_window_median.
package swm_pkg;

    localparam int WINDOW_MAX_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 8;
    localparam int CFG_W           = 7;
    localparam int LEN_RESET       = 3;

    // Per-cycle command broadcast to every sort cell
    typedef struct packed {
        logic load;    // a sample request is taken this cycle
        logic remove;  // window full: evict one copy of the oldest value
        logic clear;   // drop all cell contents
    } t_cell_ctl;

endpackage

/* sv/swm_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module swm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/swm_cell.sv */
// One slot of the sorted window: removes the evicted value and inserts the new
// sample using only its own compares and its two neighbors. Uses swm_pkg.
module swm_cell #(
    parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  swm_pkg::t_cell_ctl     i_ctl,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic [SAMPLE_BITS-1:0] i_old,
    input  logic [SAMPLE_BITS-1:0] i_up_value,
    input  logic                   i_up_valid,
    input  logic [SAMPLE_BITS-1:0] i_dn_value,
    input  logic                   i_dn_valid,
    input  logic                   i_dn_le,
    output logic [SAMPLE_BITS-1:0] o_value,
    output logic                   o_valid,
    output logic [SAMPLE_BITS-1:0] o_r_value,
    output logic                   o_r_valid,
    output logic                   o_r_le
);
    import swm_pkg::*;

    logic [SAMPLE_BITS-1:0] r_value;
    logic                   r_valid;
    logic [SAMPLE_BITS-1:0] n_value;
    logic                   n_valid;
    logic                   w_below_old;
    logic                   w_shift;
    logic [SAMPLE_BITS-1:0] w_r_value;
    logic                   w_r_valid;
    logic                   w_r_le;

    // after eviction: cells at or above the evicted slot take the upper neighbor
    assign w_below_old = r_valid & (r_value < i_old);
    assign w_shift     = i_ctl.remove & ~w_below_old;
    assign w_r_value   = w_shift ? i_up_value : r_value;
    assign w_r_valid   = w_shift ? i_up_valid : r_valid;
    assign w_r_le      = w_r_valid & (w_r_value <= i_sample);

    always_comb begin
        if (w_r_le) begin
            n_value = w_r_value;
            n_valid = w_r_valid;
        end else if (i_dn_le) begin
            n_value = i_sample;
            n_valid = 1'b1;
        end else begin
            n_value = i_dn_value;
            n_valid = i_dn_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_valid <= 1'b0;
        end else if (i_ctl.load) begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_value <= n_value;
        end
    end

    assign o_value   = r_value;
    assign o_valid   = r_valid;
    assign o_r_value = w_r_value;
    assign o_r_valid = w_r_valid;
    assign o_r_le    = w_r_le;

endmodule

/* sv/swm_sort_chain.sv */
// Row of sort cells holding the window in ascending order.
// Depends on swm_pkg and swm_cell.
module swm_sort_chain #(
    parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  swm_pkg::t_cell_ctl     i_ctl,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic [SAMPLE_BITS-1:0] i_old,
    output logic [SAMPLE_BITS-1:0] o_values [WINDOW_MAX]
);
    import swm_pkg::*;

    // index k carries links of cell k-1; index 0 is the bottom boundary
    logic [SAMPLE_BITS-1:0] w_r_value [WINDOW_MAX+1];
    logic                   w_r_valid [WINDOW_MAX+1];
    logic                   w_r_le    [WINDOW_MAX+1];
    // stored slot contents, index WINDOW_MAX is the empty top boundary
    logic [SAMPLE_BITS-1:0] w_value   [WINDOW_MAX+1];
    logic                   w_valid   [WINDOW_MAX+1];

    assign w_r_value[0]          = '0;
    assign w_r_valid[0]          = 1'b1;
    assign w_r_le[0]             = 1'b1;
    assign w_value[WINDOW_MAX]   = '0;
    assign w_valid[WINDOW_MAX]   = 1'b0;

    for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
        swm_cell #(
            .SAMPLE_BITS(SAMPLE_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (i_ctl),
            .i_sample   (i_sample),
            .i_old      (i_old),
            .i_up_value (w_value[k+1]),
            .i_up_valid (w_valid[k+1]),
            .i_dn_value (w_r_value[k]),
            .i_dn_valid (w_r_valid[k]),
            .i_dn_le    (w_r_le[k]),
            .o_value    (w_value[k]),
            .o_valid    (w_valid[k]),
            .o_r_value  (w_r_value[k+1]),
            .o_r_valid  (w_r_valid[k+1]),
            .o_r_le     (w_r_le[k+1])
        );
        assign o_values[k] = w_value[k];
    end

endmodule

/* sv/sliding_window_median.sv */
// Sliding-window median filter: top level with ring store, control and output register.
// Depends on swm_pkg, swm_ram, swm_sort_chain (swm_cell).
//
//  channel   | signals                                      | direction
//  ----------+----------------------------------------------+----------
//  sample    | i_sample_valid, o_sample_ready, i_sample     | in
//  median    | o_median_valid, i_median_ready, o_median     | out
//  config    | i_window_len_we, i_window_len                | in
//
// One sample request per cycle while o_sample_ready is high; insert and evict through
// the cell row finish in the accepting cycle. A request that fills the window sets
// r_pend; the median is then copied from the row into a single output register, raising
// o_median_valid. While the output stalls, one more request is taken into the row and
// o_sample_ready then drops. Synchronous reset and a window_len write empty the window.
module sliding_window_median #(
    parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_window_len_we,
    input  logic [swm_pkg::CFG_W-1:0] i_window_len,
    input  logic                      i_sample_valid,
    output logic                      o_sample_ready,
    input  logic [SAMPLE_BITS-1:0]    i_sample,
    output logic                      o_median_valid,
    input  logic                      i_median_ready,
    output logic [SAMPLE_BITS-1:0]    o_median
);
    import swm_pkg::*;

    localparam int LEN_W = $clog2(WINDOW_MAX + 1);
    localparam int PTR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int LEN_RST_I = (LEN_RESET > WINDOW_MAX) ? WINDOW_MAX : LEN_RESET;
    localparam logic [LEN_W-1:0] LEN_RST = LEN_W'(LEN_RST_I);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(WINDOW_MAX);

    logic [LEN_W-1:0]       r_len;
    logic [LEN_W-1:0]       n_len;
    logic [LEN_W-1:0]       r_fill;
    logic [PTR_W-1:0]       r_wpos;
    logic [PTR_W-1:0]       n_wpos;
    logic                   r_pend;
    logic                   r_out_vld;
    logic [SAMPLE_BITS-1:0] r_median;
    logic                   r_byp;
    logic [SAMPLE_BITS-1:0] r_byp_data;

    logic                   w_in_acc;
    logic                   w_copy;
    logic                   w_full;
    logic                   w_done;
    logic [PTR_W-1:0]       w_raddr;
    logic [SAMPLE_BITS-1:0] w_ram_q;
    logic [SAMPLE_BITS-1:0] w_old;
    logic [PTR_W-1:0]       w_midx;
    t_cell_ctl              w_ctl;
    logic [SAMPLE_BITS-1:0] w_values [WINDOW_MAX];

    always_comb begin
        if (i_window_len == '0) begin
            n_len = LEN_W'(1);
        end else if (int'(i_window_len) > WINDOW_MAX) begin
            n_len = LEN_MAX;
        end else begin
            n_len = LEN_W'(i_window_len);
        end
    end

    assign w_full   = (r_fill == r_len);
    assign w_done   = w_full | ((r_fill + LEN_W'(1)) == r_len);
    assign w_copy   = r_pend & (~r_out_vld | i_median_ready);
    assign w_in_acc = i_sample_valid & o_sample_ready;
    assign n_wpos   = (r_wpos == PTR_W'(r_len - LEN_W'(1))) ? '0 : r_wpos + PTR_W'(1);
    assign w_raddr  = w_in_acc ? n_wpos : r_wpos;
    assign w_old    = r_byp ? r_byp_data : w_ram_q;
    assign w_midx   = PTR_W'((r_len - LEN_W'(1)) >> 1);

    assign w_ctl.load   = w_in_acc;
    assign w_ctl.remove = w_full;
    assign w_ctl.clear  = i_window_len_we;

    swm_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_MAX),
        .ADDR_W(PTR_W)
    ) u_ring (
        .i_clk  (i_clk),
        .i_we   (w_in_acc),
        .i_waddr(r_wpos),
        .i_wdata(i_sample),
        .i_raddr(w_raddr),
        .o_rdata(w_ram_q)
    );

    swm_sort_chain #(
        .WINDOW_MAX (WINDOW_MAX),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_sample(i_sample),
        .i_old   (w_old),
        .o_values(w_values)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= LEN_RST;
            r_fill    <= '0;
            r_wpos    <= '0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
            r_byp     <= 1'b0;
        end else if (i_window_len_we) begin
            r_len     <= n_len;
            r_fill    <= '0;
            r_wpos    <= '0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
            r_byp     <= 1'b0;
        end else begin
            // ring read one slot ahead; a one-slot ring must see the sample just written
            r_byp <= w_in_acc & (n_wpos == r_wpos);
            if (w_in_acc) begin
                r_wpos <= n_wpos;
                if (!w_full) begin
                    r_fill <= r_fill + LEN_W'(1);
                end
            end
            if (w_in_acc && w_done) begin
                r_pend <= 1'b1;
            end else if (w_copy) begin
                r_pend <= 1'b0;
            end
            if (w_copy) begin
                r_out_vld <= 1'b1;
            end else if (i_median_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_byp_data <= i_sample;
        end
        if (w_copy) begin
            r_median <= w_values[w_midx];
        end
    end

    assign o_sample_ready = ~r_pend | w_copy;
    assign o_median_valid = r_out_vld;
    assign o_median       = r_median;

endmodule
